// ----- hdl/srm_pkg.sv -----
// Shared types, address map constants and the address decode helper of the servo register map.
package srm_pkg;

   // Fixed address map layout (32 servo slots regardless of servos in use).
   localparam int SLOTS       = 32;
   localparam int LIMIT_BASE  = SLOTS * 2;
   localparam int POS_BASE    = LIMIT_BASE + SLOTS * 4;
   localparam int STAT_BASE   = POS_BASE + SLOTS * 2;
   localparam int BITMAPS     = 4;
   localparam int MISC_BASE   = STAT_BASE + BITMAPS;
   localparam int BITMAP_BITS = 8;

   localparam int SERVOS_DEFAULT     = 32;
   localparam int MISC_BYTES_DEFAULT = 16;

   localparam int ADDR_W    = 9;
   localparam int DATA_W    = 8;
   localparam int SIDX_W    = 5;
   localparam int COUNT_W   = 6;
   localparam int REQ_TDATA_W = 32;
   localparam logic [COUNT_W-1:0] ACTIVE_RESET = 6'd32;

   typedef enum logic [1:0] {
      KIND_WRITE    = 2'd0,
      KIND_READ     = 2'd1,
      KIND_POSITION = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      RGN_SPEED,
      RGN_LIMIT,
      RGN_POS,
      RGN_STAT,
      RGN_MISC
   } region_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCAN,
      ST_DONE
   } state_type;

   function automatic region_type addr_region(input logic [ADDR_W-1:0] addr);
      region_type rgn;
      if (addr < ADDR_W'(LIMIT_BASE)) begin
         rgn = RGN_SPEED;
      end else if (addr < ADDR_W'(POS_BASE)) begin
         rgn = RGN_LIMIT;
      end else if (addr < ADDR_W'(STAT_BASE)) begin
         rgn = RGN_POS;
      end else if (addr < ADDR_W'(MISC_BASE)) begin
         rgn = RGN_STAT;
      end else begin
         rgn = RGN_MISC;
      end
      return rgn;
   endfunction

endpackage

// ----- hdl/srm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module srm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/servo_register_map_unit.sv -----
// Top level of the servo register map: sequencer, address decode and storage.
// Sequence: each input beat is latched and executed; writes, position reports and kind 3
//   items then finish, plain reads add a read step and reached-target bitmap reads a scan
//   step (one shared target/position comparator is stepped over the 8 servos of the byte).
// The done step loads the result into the output register, waiting while that register
//   holds a result not yet taken; the next beat is taken once the result sits there.
// Reset (synchronous, active high): sweep zeros into every store, one entry a cycle;
//   no input beat is taken meanwhile, configuration writes are. active_servos resets to 32.
module servo_register_map_unit #(
   parameter int SERVOS     = srm_pkg::SERVOS_DEFAULT,
   parameter int MISC_BYTES = srm_pkg::MISC_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // [8:0] address, [16:9] write_data, [21:17] servo_index, [29:22] position_value
   input  logic [31:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]  req_tuser,
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data
   output logic [7:0]  rsp_tdata,
   // [0] limits_changed
   output logic [0:0]  rsp_tuser,
   // configuration: active_servos
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data
);

   localparam int SW        = (SERVOS > 1) ? $clog2(SERVOS) : 1;
   localparam int LIM_DEPTH = 2 * SERVOS;
   localparam int LW        = $clog2(LIM_DEPTH);
   localparam int MW        = (MISC_BYTES > 1) ? $clog2(MISC_BYTES) : 1;
   localparam int CLR_DEPTH = (LIM_DEPTH > MISC_BYTES) ? LIM_DEPTH : MISC_BYTES;
   localparam int CW        = $clog2(CLR_DEPTH + 1);
   localparam int AW        = srm_pkg::ADDR_W;
   localparam int DW        = srm_pkg::DATA_W;
   localparam int NW        = srm_pkg::COUNT_W;

   // ---------------------------------------------------------------- state
   srm_pkg::state_type state_ff, state_in;

   logic [CW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [3:0]    bm_cnt_ff, bm_cnt_in;
   logic          bm_hit_ff, bm_hit_in;
   logic [2:0]    bm_bit_ff, bm_bit_in;

   logic [NW-1:0] active_ff, active_in;

   // latched item
   srm_pkg::kind_type        item_kind_ff;
   logic [AW-1:0]            item_addr_ff;
   logic [DW-1:0]            item_wdata_ff;
   logic [srm_pkg::SIDX_W-1:0] item_sidx_ff;
   logic [DW-1:0]            item_pos_ff;

   // working result and output register
   logic [DW-1:0] rd_ff, rd_in;
   logic          chg_ff, chg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_data_ff;
   logic          rsp_user_ff;

   // sequencer outputs
   logic clearing, exec_en, read_en, scan_en, done_en, load_rsp;

   // --------------------------------------------------------------- decode
   srm_pkg::region_type rgn;
   logic [4:0]    st_s;
   logic          st_ok;
   logic [6:0]    lim_off;
   logic [5:0]    lim_e;
   logic          lim_ok;
   logic [5:0]    pos_s;
   logic          pos_ok;
   logic [1:0]    stat_r;
   logic [AW-1:0] misc_m;
   logic          misc_ok;
   logic          sidx_ok;
   logic [4:0]    bm_idx;
   logic [NW-1:0] count_eff;
   logic          is_write, is_read, is_pos;

   always_comb begin
      rgn     = srm_pkg::addr_region(item_addr_ff);
      st_s    = item_addr_ff[5:1];
      st_ok   = {1'b0, st_s} < NW'(SERVOS);
      lim_off = 7'(item_addr_ff - AW'(srm_pkg::LIMIT_BASE));
      lim_e   = {lim_off[6:2], lim_off[1]};
      lim_ok  = {1'b0, lim_off[6:2]} < NW'(SERVOS);
      pos_s   = 6'(item_addr_ff - AW'(srm_pkg::POS_BASE));
      pos_ok  = pos_s < NW'(SERVOS);
      stat_r  = item_addr_ff[1:0];
      misc_m  = item_addr_ff - AW'(srm_pkg::MISC_BASE);
      misc_ok = misc_m < AW'(MISC_BYTES);
      sidx_ok = {1'b0, item_sidx_ff} < NW'(SERVOS);
      bm_idx  = {stat_r, bm_cnt_ff[2:0]};
      count_eff = (active_ff > NW'(SERVOS)) ? NW'(SERVOS) : active_ff;
      is_write = (item_kind_ff == srm_pkg::KIND_WRITE);
      is_read  = (item_kind_ff == srm_pkg::KIND_READ);
      is_pos   = (item_kind_ff == srm_pkg::KIND_POSITION);
   end

   // ------------------------------------------------------------- storage
   logic          speed_we, target_we, pos_we, lim_hi_we, lim_lo_we, misc_we;
   logic [SW-1:0] speed_wa, target_wa, pos_wa, target_ra, pos_ra;
   logic [LW-1:0] lim_a;
   logic [MW-1:0] misc_wa;
   logic [DW-1:0] wr_byte, pos_byte;
   logic [DW-1:0] speed_rd, target_rd, pos_rd, lim_hi_rd, lim_lo_rd, misc_rd;
   logic          clr_servo, clr_lim, clr_misc;

   always_comb begin
      clr_servo = clearing && (clr_cnt_ff < CW'(SERVOS));
      clr_lim   = clearing && (clr_cnt_ff < CW'(LIM_DEPTH));
      clr_misc  = clearing && (clr_cnt_ff < CW'(MISC_BYTES));
      wr_byte   = clearing ? '0 : item_wdata_ff;
      pos_byte  = clearing ? '0 : item_pos_ff;

      speed_we  = clr_servo || (exec_en && is_write && rgn == srm_pkg::RGN_SPEED
                                && st_ok && !item_addr_ff[0]);
      target_we = clr_servo || (exec_en && is_write && rgn == srm_pkg::RGN_SPEED
                                && st_ok && item_addr_ff[0]);
      pos_we    = clr_servo || (exec_en && is_pos && sidx_ok);
      lim_hi_we = clr_lim || (exec_en && is_write && rgn == srm_pkg::RGN_LIMIT
                              && lim_ok && !lim_off[0]);
      lim_lo_we = clr_lim || (exec_en && is_write && rgn == srm_pkg::RGN_LIMIT
                              && lim_ok && lim_off[0]);
      misc_we   = clr_misc || (exec_en && is_write && rgn == srm_pkg::RGN_MISC && misc_ok);

      speed_wa  = clearing ? clr_cnt_ff[SW-1:0] : st_s[SW-1:0];
      target_wa = speed_wa;
      pos_wa    = clearing ? clr_cnt_ff[SW-1:0] : item_sidx_ff[SW-1:0];
      lim_a     = clearing ? clr_cnt_ff[LW-1:0] : lim_e[LW-1:0];
      misc_wa   = clearing ? clr_cnt_ff[MW-1:0] : misc_m[MW-1:0];

      // the scan steps the target and position stores over one bitmap byte
      target_ra = scan_en ? bm_idx[SW-1:0] : st_s[SW-1:0];
      pos_ra    = scan_en ? bm_idx[SW-1:0] : pos_s[SW-1:0];
   end

   srm_ram #(.WIDTH(DW), .DEPTH(SERVOS)) u_speed (
      .clock(clock), .wr_en(speed_we), .wr_addr(speed_wa), .wr_data(wr_byte),
      .rd_addr(st_s[SW-1:0]), .rd_data(speed_rd));

   srm_ram #(.WIDTH(DW), .DEPTH(SERVOS)) u_target (
      .clock(clock), .wr_en(target_we), .wr_addr(target_wa), .wr_data(wr_byte),
      .rd_addr(target_ra), .rd_data(target_rd));

   srm_ram #(.WIDTH(DW), .DEPTH(SERVOS)) u_position (
      .clock(clock), .wr_en(pos_we), .wr_addr(pos_wa), .wr_data(pos_byte),
      .rd_addr(pos_ra), .rd_data(pos_rd));

   // pulse limits split into high and low byte stores: every bus write is one byte
   srm_ram #(.WIDTH(DW), .DEPTH(LIM_DEPTH)) u_limit_hi (
      .clock(clock), .wr_en(lim_hi_we), .wr_addr(lim_a), .wr_data(wr_byte),
      .rd_addr(lim_a), .rd_data(lim_hi_rd));

   srm_ram #(.WIDTH(DW), .DEPTH(LIM_DEPTH)) u_limit_lo (
      .clock(clock), .wr_en(lim_lo_we), .wr_addr(lim_a), .wr_data(wr_byte),
      .rd_addr(lim_a), .rd_data(lim_lo_rd));

   srm_ram #(.WIDTH(DW), .DEPTH(MISC_BYTES)) u_misc (
      .clock(clock), .wr_en(misc_we), .wr_addr(misc_wa), .wr_data(wr_byte),
      .rd_addr(misc_m[MW-1:0]), .rd_data(misc_rd));

   // ------------------------------------------------------ next state logic
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srm_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == CW'(CLR_DEPTH - 1)) state_in = srm_pkg::ST_IDLE;
         end
         srm_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = srm_pkg::ST_EXEC;
         end
         srm_pkg::ST_EXEC: begin
            if (is_read && rgn == srm_pkg::RGN_STAT) begin
               state_in = srm_pkg::ST_SCAN;
            end else if (is_read) begin
               state_in = srm_pkg::ST_READ;
            end else begin
               state_in = srm_pkg::ST_DONE;
            end
         end
         srm_pkg::ST_READ: begin
            state_in = srm_pkg::ST_DONE;
         end
         srm_pkg::ST_SCAN: begin
            if (bm_cnt_ff == 4'(srm_pkg::BITMAP_BITS)) state_in = srm_pkg::ST_DONE;
         end
         srm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = srm_pkg::ST_IDLE;
         end
         default: begin
            state_in = srm_pkg::ST_IDLE;
         end
      endcase
   end

   // --------------------------------------------------------- state outputs
   always_comb begin
      clearing   = 1'b0;
      req_tready = 1'b0;
      exec_en    = 1'b0;
      read_en    = 1'b0;
      scan_en    = 1'b0;
      done_en    = 1'b0;
      case (state_ff)
         srm_pkg::ST_CLEAR: clearing   = 1'b1;
         srm_pkg::ST_IDLE:  req_tready = 1'b1;
         srm_pkg::ST_EXEC:  exec_en    = 1'b1;
         srm_pkg::ST_READ:  read_en    = 1'b1;
         srm_pkg::ST_SCAN:  scan_en    = 1'b1;
         srm_pkg::ST_DONE:  done_en    = 1'b1;
         default: begin
            clearing = 1'b0;
         end
      endcase
      load_rsp = done_en && (!rsp_valid_ff || rsp_tready);
   end

   // ----------------------------------------------------------- datapath
   always_comb begin
      clr_cnt_in = clearing ? clr_cnt_ff + CW'(1) : '0;
      bm_cnt_in  = bm_cnt_ff;
      bm_hit_in  = 1'b0;
      bm_bit_in  = bm_cnt_ff[2:0];
      rd_in      = rd_ff;
      chg_in     = chg_ff;
      active_in  = (csr_valid && csr_ready) ? csr_data : active_ff;

      if (exec_en) begin
         // limits_changed comes from the low-byte commit alone
         rd_in     = '0;
         chg_in    = lim_lo_we;
         bm_cnt_in = '0;
      end

      if (read_en) begin
         case (rgn)
            srm_pkg::RGN_SPEED: rd_in = !st_ok ? '0 :
                                        (item_addr_ff[0] ? target_rd : speed_rd);
            srm_pkg::RGN_LIMIT: rd_in = !lim_ok ? '0 : (lim_off[0] ? lim_lo_rd : lim_hi_rd);
            srm_pkg::RGN_POS:   rd_in = pos_ok ? pos_rd : '0;
            srm_pkg::RGN_MISC:  rd_in = misc_ok ? misc_rd : '0;
            default:            rd_in = '0;
         endcase
      end

      if (scan_en) begin
         // issue one servo per cycle, compare it in the cycle its read data returns
         if (bm_cnt_ff != 4'(srm_pkg::BITMAP_BITS)) begin
            bm_cnt_in = bm_cnt_ff + 4'd1;
            bm_hit_in = {1'b0, bm_idx} < count_eff;
         end
         if (bm_hit_ff && (target_rd == pos_rd)) begin
            rd_in[bm_bit_ff] = 1'b1;
         end
      end

      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srm_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         bm_cnt_ff    <= '0;
         bm_hit_ff    <= 1'b0;
         active_ff    <= srm_pkg::ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         bm_cnt_ff    <= bm_cnt_in;
         bm_hit_ff    <= bm_hit_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bm_bit_ff <= bm_bit_in;
      rd_ff     <= rd_in;
      chg_ff    <= chg_in;
      if (req_tvalid && req_tready) begin
         item_kind_ff  <= srm_pkg::kind_type'(req_tuser);
         item_addr_ff  <= req_tdata[8:0];
         item_wdata_ff <= req_tdata[16:9];
         item_sidx_ff  <= req_tdata[21:17];
         item_pos_ff   <= req_tdata[29:22];
      end
      if (load_rsp) begin
         rsp_data_ff <= rd_ff;
         rsp_user_ff <= chg_ff;
      end
   end

   assign csr_ready    = 1'b1;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

   // ------------------------------------------------------------ assertions
   // a limit commit is a write, so it never carries read data
   a_chg_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("limits_changed result carries nonzero read data");

   // a fresh result only comes out of the done step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == srm_pkg::ST_DONE))
      else $error("response raised outside the done step");

   // the bitmap scan never runs past one byte
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_en |-> bm_cnt_ff <= 4'(srm_pkg::BITMAP_BITS))
      else $error("bitmap scan counter overran");

   // no item is taken before the store sweep has finished
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clearing && clr_cnt_ff != CW'(CLR_DEPTH - 1) |=> !req_tready)
      else $error("input taken during store sweep");

endmodule
